### sv/trle_pkg.sv
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants of the scanline run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package trle_pkg;

  localparam int unsigned PACKET_MAX  = 128;  // 2 .. 128
  localparam int unsigned BUF_DEPTH   = 128;
  localparam int unsigned BUF_AW      = $clog2(BUF_DEPTH);
  localparam int unsigned LANES       = 4;
  localparam int unsigned LANE_W      = $clog2(LANES);
  localparam int unsigned ROWS        = 2 * BUF_DEPTH / LANES;
  localparam int unsigned ROW_W       = $clog2(ROWS);
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned QDEPTH      = 4;    // power of two
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] PKT_MAX_C = 8'(PACKET_MAX);
  localparam logic [7:0] RAW_LIMIT = 8'(MAX_RESULTS * LANES - 3);

  typedef logic [23:0]       pixel_t;
  typedef logic [7:0]        count_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  typedef enum logic [1:0] {
    CMD_RUN    = 2'd0,
    CMD_SINGLE = 2'd1,
    CMD_RAW    = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic      bank;
    count_t    count;
    pixel_t    pixel;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [BUF_AW-1:0] idx;
    pixel_t            data;
  } buf_wr_t;

  typedef struct packed {
    logic done;
    logic bank;
  } bank_rel_t;

endpackage

`default_nettype wire

### sv/tga_rle_scanline_encoder.sv
// Flow: the front takes one pixel per cycle while not stalled and registers packet commands in
//   the command queue. The back loads a run beat into the output register in B_IDLE; a raw
//   packet is popped in B_IDLE, then each beat of up to four pixels is read in B_READ and
//   sent in B_SEND. The back holds its beats while the output is stalled.
// The front stalls when the command queue lacks two free slots or a raw flush needs a bank
//   that is still being drained. Reset is asynchronous; the pixel buffer is not cleared.
// ----------------------------------------------------------------------------
// tga_rle_scanline_encoder
// Run-length packet encoder for 24-bit scanlines, decoupled front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_scanline_encoder import trle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [23:0] pixel_value_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       has_header_o,
  output logic [7:0] header_byte_o,
  output logic [23:0] pix_first_o,
  output logic [23:0] pix_second_o,
  output logic [23:0] pix_third_o,
  output logic [23:0] pix_fourth_o,
  output logic [2:0] pix_count_o,
  output logic       packet_end_o
);

  qcnt_t     q_free;
  logic      push0, push1, q_valid, q_pop;
  cmd_t      cmd0, cmd1, q_head;
  buf_wr_t   buf_wr;
  bank_rel_t rel;

  trle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .pixel_value_i (pixel_value_i),
    .line_end_i    (line_end_i),
    .in_stall_o    (in_stall_o),
    .q_free_i      (q_free),
    .push0_o       (push0),
    .push1_o       (push1),
    .cmd0_o        (cmd0),
    .cmd1_o        (cmd1),
    .wr_o          (buf_wr),
    .rel_i         (rel)
  );

  trle_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .cmd0_i  (cmd0),
    .cmd1_i  (cmd1),
    .free_o  (q_free),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  trle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (buf_wr),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .rel_o         (rel),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .has_header_o  (has_header_o),
    .header_byte_o (header_byte_o),
    .pix_first_o   (pix_first_o),
    .pix_second_o  (pix_second_o),
    .pix_third_o   (pix_third_o),
    .pix_fourth_o  (pix_fourth_o),
    .pix_count_o   (pix_count_o),
    .packet_end_o  (packet_end_o)
  );

endmodule

`default_nettype wire

### sv/trle_front.sv
// ----------------------------------------------------------------------------
// trle_front
// Accepts pixels, tracks the open packet and issues packet commands.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_front import trle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  pixel_t    pixel_value_i,
  input  logic      line_end_i,
  output logic      in_stall_o,
  input  qcnt_t     q_free_i,
  output logic      push0_o,
  output logic      push1_o,
  output cmd_t      cmd0_o,
  output cmd_t      cmd1_o,
  output buf_wr_t   wr_o,
  input  bank_rel_t rel_i
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_ONE  = 4'b0010,
    M_RUN  = 4'b0100,
    M_RAW  = 4'b1000
  } mode_e;

  mode_e      mode_q, mode_d;
  count_t     count_q, count_d;
  pixel_t     last_q, last_d;
  logic       wbank_q, wbank_d;
  logic [1:0] busy_q, busy_d;

  logic    accept, bank_flush, eq, p0, p1;
  count_t  grow;
  cmd_t    c0, c1;
  buf_wr_t wr;

  assign eq   = (pixel_value_i == last_q);
  assign grow = count_q + 8'd1;

  always_comb begin
    mode_d     = mode_q;
    count_d    = count_q;
    last_d     = last_q;
    wbank_d    = wbank_q;
    p0         = 1'b0;
    p1         = 1'b0;
    bank_flush = 1'b0;
    c0         = '{kind: CMD_RUN, bank: wbank_q, count: count_q, pixel: last_q};
    c1         = '{kind: CMD_SINGLE, bank: wbank_q, count: 8'd1, pixel: pixel_value_i};
    wr         = '{en: 1'b0, bank: wbank_q, idx: '0, data: pixel_value_i};
    case (mode_q)
      M_ONE: begin
        count_d = 8'd2;
        if (eq) begin
          mode_d = M_RUN;
        end else begin
          wr.en  = 1'b1;
          wr.idx = BUF_AW'(1);
          last_d = pixel_value_i;
          mode_d = M_RAW;
        end
        if (PKT_MAX_C <= 8'd2 || line_end_i) begin
          p0       = 1'b1;
          c0.count = 8'd2;
          if (!eq) begin
            c0.kind    = CMD_RAW;
            bank_flush = 1'b1;
            wbank_d    = ~wbank_q;
          end
          mode_d  = M_IDLE;
          count_d = '0;
        end
      end
      M_RUN: begin
        if (eq) begin
          count_d = grow;
          if (grow >= PKT_MAX_C || line_end_i) begin
            p0       = 1'b1;
            c0.count = grow;
            mode_d   = M_IDLE;
            count_d  = '0;
          end
        end else begin
          p0      = 1'b1;
          wr.en   = 1'b1;
          last_d  = pixel_value_i;
          count_d = 8'd1;
          mode_d  = M_ONE;
          if (line_end_i) begin
            p1      = 1'b1;
            mode_d  = M_IDLE;
            count_d = '0;
          end
        end
      end
      M_RAW: begin
        c0.kind    = CMD_RAW;
        p0         = 1'b0;
        if (!eq || (line_end_i && count_q >= RAW_LIMIT)) begin
          wr.en   = 1'b1;
          wr.idx  = count_q[BUF_AW-1:0];
          count_d = grow;
          last_d  = pixel_value_i;
          if (grow >= PKT_MAX_C || line_end_i) begin
            p0         = 1'b1;
            c0.count   = grow;
            bank_flush = 1'b1;
            wbank_d    = ~wbank_q;
            mode_d     = M_IDLE;
            count_d    = '0;
          end
        end else begin
          p0         = 1'b1;
          bank_flush = 1'b1;
          wbank_d    = ~wbank_q;
          wr.en      = 1'b1;
          wr.bank    = ~wbank_q;
          last_d     = pixel_value_i;
          count_d    = 8'd1;
          mode_d     = M_ONE;
          if (line_end_i) begin
            p1      = 1'b1;
            mode_d  = M_IDLE;
            count_d = '0;
          end
        end
      end
      default: begin
        wr.en   = 1'b1;
        last_d  = pixel_value_i;
        count_d = 8'd1;
        mode_d  = M_ONE;
        if (line_end_i) begin
          p1      = 1'b1;
          mode_d  = M_IDLE;
          count_d = '0;
        end
      end
    endcase
  end

  // a bank flush moves writing to the other bank, which must be drained
  assign in_stall_o = (q_free_i < qcnt_t'(2)) || (bank_flush && busy_q[~wbank_q]);
  assign accept     = in_valid_i && !in_stall_o;

  assign push0_o = accept && (p0 || p1);
  assign push1_o = accept && p0 && p1;
  assign cmd0_o  = p0 ? c0 : c1;
  assign cmd1_o  = c1;

  always_comb begin
    wr_o    = wr;
    wr_o.en = wr.en && accept;
  end

  always_comb begin
    busy_d = busy_q;
    if (rel_i.done) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept && bank_flush) begin
      busy_d[wbank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      count_q <= '0;
      last_q  <= '0;
      wbank_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        mode_q  <= mode_d;
        count_q <= count_d;
        last_q  <= last_d;
        wbank_q <= wbank_d;
      end
    end
  end

`ifndef SYNTH
  a_wr_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !busy_q[wr_o.bank])
    else $error("pixel written into a bank still being drained");

  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < PKT_MAX_C)
    else $error("open packet reached its size limit without closing");
`endif

endmodule

`default_nettype wire

### sv/trle_cmd_queue.sv
// ----------------------------------------------------------------------------
// trle_cmd_queue
// Short command queue between front and back, up to two pushes per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_cmd_queue import trle_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push0_i,
  input  logic  push1_i,
  input  cmd_t  cmd0_i,
  input  cmd_t  cmd1_i,
  output qcnt_t free_o,
  output logic  valid_o,
  output cmd_t  head_o,
  input  logic  pop_i
);

  cmd_t              ent_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q, wptr1;
  qcnt_t             count_q;

  assign wptr1   = wptr_q + QPTR_W'(1);
  assign valid_o = (count_q != '0);
  assign head_o  = ent_q[rptr_q];
  assign free_o  = qcnt_t'(QDEPTH) - count_q;

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      ent_q[wptr_q] <= cmd0_i;
    end
    if (push1_i) begin
      ent_q[wptr1] <= cmd1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + QPTR_W'(push0_i) + QPTR_W'(push1_i);
      rptr_q  <= rptr_q + QPTR_W'(pop_i);
      count_q <= count_q + qcnt_t'(push0_i) + qcnt_t'(push1_i) - qcnt_t'(pop_i);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qcnt_t'(push0_i) + qcnt_t'(push1_i)) <= free_o)
    else $error("command queue overflow");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

### sv/trle_back.sv
// ----------------------------------------------------------------------------
// trle_back
// Pixel buffer and packet emitter: turns commands into result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_back import trle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  buf_wr_t   wr_i,
  input  logic      q_valid_i,
  input  cmd_t      q_head_i,
  output logic      q_pop_o,
  output bank_rel_t rel_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic      has_header_o,
  output logic [7:0] header_byte_o,
  output pixel_t    pix_first_o,
  output pixel_t    pix_second_o,
  output pixel_t    pix_third_o,
  output pixel_t    pix_fourth_o,
  output logic [2:0] pix_count_o,
  output logic      packet_end_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_SEND = 3'b100
  } bstate_e;

  bstate_e st_q, st_d;
  logic    cur_bank_q;
  count_t  cur_n_q, pos_q, pos_d;
  logic    ld_cur, rd_en, load, out_free;

  logic [ROW_W-1:0] rd_row;
  pixel_t           rd_q [LANES];

  logic        ov_q, hh_q, hh_d, pe_q, pe_d;
  logic [7:0]  hb_q, hb_d;
  logic [2:0]  pc_q, pc_d;
  pixel_t      px_q [LANES];
  pixel_t      px_d [LANES];
  count_t      rem, take, head_m1, cur_m1;

  assign rd_row = {cur_bank_q, pos_q[BUF_AW-1:LANE_W]};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pixel_t mem [ROWS];
    always_ff @(posedge clk_i) begin
      if (wr_i.en && wr_i.idx[LANE_W-1:0] == LANE_W'(l)) begin
        mem[{wr_i.bank, wr_i.idx[BUF_AW-1:LANE_W]}] <= wr_i.data;
      end
      if (rd_en) begin
        rd_q[l] <= mem[rd_row];
      end
    end
  end

  assign out_free = !ov_q || !out_stall_i;
  assign rem      = cur_n_q - pos_q;
  assign take     = (rem > 8'(LANES)) ? 8'(LANES) : rem;
  assign head_m1  = q_head_i.count - 8'd1;
  assign cur_m1   = cur_n_q - 8'd1;

  always_comb begin
    st_d    = st_q;
    pos_d   = pos_q;
    ld_cur  = 1'b0;
    rd_en   = 1'b0;
    load    = 1'b0;
    q_pop_o = 1'b0;
    rel_o   = '{done: 1'b0, bank: cur_bank_q};
    hh_d    = 1'b1;
    hb_d    = '0;
    pc_d    = 3'd1;
    pe_d    = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      px_d[i] = '0;
    end
    case (st_q)
      B_IDLE: begin
        if (q_valid_i) begin
          case (q_head_i.kind)
            CMD_RUN, CMD_SINGLE: begin
              if (out_free) begin
                q_pop_o = 1'b1;
                load    = 1'b1;
                px_d[0] = q_head_i.pixel;
                if (q_head_i.kind == CMD_RUN) begin
                  hb_d = {1'b1, head_m1[6:0]};
                end
              end
            end
            CMD_RAW: begin
              q_pop_o = 1'b1;
              ld_cur  = 1'b1;
              pos_d   = '0;
              st_d    = B_READ;
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      B_READ: begin
        rd_en = 1'b1;
        st_d  = B_SEND;
      end
      B_SEND: begin
        if (out_free) begin
          load = 1'b1;
          hh_d = (pos_q == '0);
          hb_d = (pos_q == '0) ? {1'b0, cur_m1[6:0]} : 8'd0;
          pc_d = take[2:0];
          pe_d = (rem <= 8'(LANES));
          for (int i = 0; i < LANES; i++) begin
            px_d[i] = (8'(i) < take) ? rd_q[i] : '0;
          end
          if (rem <= 8'(LANES)) begin
            rel_o.done = 1'b1;
            st_d       = B_IDLE;
          end else begin
            pos_d = pos_q + 8'(LANES);
            st_d  = B_READ;
          end
        end
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_cur) begin
      cur_bank_q <= q_head_i.bank;
      cur_n_q    <= q_head_i.count;
    end
    if (load) begin
      hh_q <= hh_d;
      hb_q <= hb_d;
      pc_q <= pc_d;
      pe_q <= pe_d;
      for (int i = 0; i < LANES; i++) begin
        px_q[i] <= px_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= B_IDLE;
      pos_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign has_header_o  = hh_q;
  assign header_byte_o = hb_q;
  assign pix_first_o   = px_q[0];
  assign pix_second_o  = px_q[1];
  assign pix_third_o   = px_q[2];
  assign pix_fourth_o  = px_q[3];
  assign pix_count_o   = pc_q;
  assign packet_end_o  = pe_q;

`ifndef SYNTH
  a_pix_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (pc_q != 3'd0 && pc_q <= 3'(LANES)))
    else $error("result beat with bad pixel count");

  a_send_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_SEND) |-> ($past(st_q) == B_READ || $past(st_q) == B_SEND))
    else $error("buffer data used without a read");
`endif

endmodule

`default_nettype wire

### dv/tb_tga_rle_scanline_encoder.sv
// ----------------------------------------------------------------------------
// tb_tga_rle_scanline_encoder
// Self-checking bench for the scanline run-length encoder. Pixels go in on a
// valid/stall channel; a behavioral packet builder predicts every output beat,
// and a monitor compares each accepted beat field by field, in order. Directed
// tests cover single-pixel lines, runs, raw packets, the 128-pixel limit and
// the result cap at line end. Later tests add a long output hold-off and
// random scanlines, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_tga_rle_scanline_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import trle_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_PIXELS = 50;

  typedef enum logic [1:0] {PK_IDLE, PK_ONE, PK_RUN, PK_RAW} pack_mode_e;

  typedef struct packed {
    logic             has_header;
    logic [7:0]       header;
    pixel_t [3:0]     pix;
    logic [2:0]       count;
    logic             pkt_end;
  } beat_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [23:0] pixel_value_i = '0;
  logic        line_end_i    = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic        has_header_o;
  logic [7:0]  header_byte_o;
  logic [23:0] pix_first_o;
  logic [23:0] pix_second_o;
  logic [23:0] pix_third_o;
  logic [23:0] pix_fourth_o;
  logic [2:0]  pix_count_o;
  logic        packet_end_o;

  // packet builder state
  pixel_t      pack_pix [BUF_DEPTH];
  int unsigned pack_len  = 0;
  pack_mode_e  pack_mode = PK_IDLE;
  pixel_t      pack_last = '0;
  beat_t       pending_beats [$];

  beat_t       want_beat;
  pixel_t      prev_pix    = '0;
  pixel_t      palette [4];
  int unsigned errors      = 0;
  int unsigned pixels_sent = 0;
  int unsigned lines_sent  = 0;
  int unsigned beats_seen  = 0;
  int unsigned cycles      = 0;
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  int unsigned rx_wait     = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_left   = 0;

  tga_rle_scanline_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .line_end_i    (line_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .has_header_o  (has_header_o),
    .header_byte_o (header_byte_o),
    .pix_first_o   (pix_first_o),
    .pix_second_o  (pix_second_o),
    .pix_third_o   (pix_third_o),
    .pix_fourth_o  (pix_fourth_o),
    .pix_count_o   (pix_count_o),
    .packet_end_o  (packet_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void emit_packet();
    beat_t       b;
    int unsigned pos;
    int unsigned take;
    int unsigned i;
    if (pack_mode == PK_RUN) begin
      b            = '0;
      b.has_header = 1'b1;
      b.header     = {1'b1, 7'(pack_len - 1)};
      b.pix[0]     = pack_pix[0];
      b.count      = 3'd1;
      b.pkt_end    = 1'b1;
      pending_beats.push_back(b);
    end else if (pack_mode != PK_IDLE) begin
      pos = 0;
      while (pos < pack_len) begin
        take         = (pack_len - pos > LANES) ? LANES : pack_len - pos;
        b            = '0;
        b.has_header = (pos == 0);
        b.header     = (pos == 0) ? {1'b0, 7'(pack_len - 1)} : 8'd0;
        for (i = 0; i < take; i++) b.pix[i] = pack_pix[pos + i];
        b.count      = 3'(take);
        b.pkt_end    = (pos + take >= pack_len);
        pending_beats.push_back(b);
        pos += take;
      end
    end
    pack_mode = PK_IDLE;
    pack_len  = 0;
  endfunction

  function automatic void open_packet(pixel_t x, logic le);
    pack_pix[0] = x;
    pack_last   = x;
    pack_len    = 1;
    pack_mode   = PK_ONE;
    if (le) emit_packet();
  endfunction

  function automatic void encode_pixel(pixel_t x, logic le);
    case (pack_mode)
      PK_ONE: begin
        if (x == pack_last) begin
          pack_mode = PK_RUN;
        end else begin
          pack_pix[1] = x;
          pack_last   = x;
          pack_mode   = PK_RAW;
        end
        pack_len = 2;
        if (pack_len >= PACKET_MAX || le) emit_packet();
      end
      PK_RUN: begin
        if (x == pack_last) begin
          pack_len++;
          if (pack_len >= PACKET_MAX || le) emit_packet();
        end else begin
          emit_packet();
          open_packet(x, le);
        end
      end
      PK_RAW: begin
        // a line-end repeat joins a raw packet that already needs every result slot
        if (x != pack_last || (le && (pack_len + 3) / LANES >= MAX_RESULTS)) begin
          pack_pix[pack_len % BUF_DEPTH] = x;
          pack_len++;
          pack_last = x;
          if (pack_len >= PACKET_MAX || le) emit_packet();
        end else begin
          emit_packet();
          open_packet(x, le);
        end
      end
      default: open_packet(x, le);
    endcase
  endfunction

  // ------------------------------------------------------------------- driver
  task automatic send_pixel(pixel_t x, logic le);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= x;
    line_end_i    <= le;
    do @(posedge clk_i); while (in_stall_o);
    encode_pixel(x, le);
    prev_pix = x;
    pixels_sent++;
    if (le) lines_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // n pixels with every neighbor different, optionally closed by a line-end repeat
  task automatic send_distinct(int unsigned n, pixel_t base, bit close_repeat);
    int unsigned i;
    for (i = 0; i < n; i++)
      send_pixel(base + 24'(i) * 24'h010203, !close_repeat && i == n - 1);
    if (close_repeat) send_pixel(prev_pix, 1'b1);
  endtask

  function automatic pixel_t pick_pixel();
    case ($urandom_range(0, 3))
      0, 1:    return 24'($urandom);
      2:       return palette[$urandom_range(0, 3)];
      default: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    endcase
  endfunction

  task automatic send_scanline(int unsigned len);
    int unsigned done_n;
    int unsigned seg;
    int unsigned k;
    pixel_t      p;
    for (k = 0; k < 4; k++) palette[k] = 24'($urandom);
    done_n = 0;
    while (done_n < len) begin
      case ($urandom_range(0, 3))
        0: begin
          seg = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 140) : $urandom_range(2, 12);
          p   = pick_pixel();
          for (k = 0; k < seg && done_n < len; k++) begin
            send_pixel(p, done_n == len - 1);
            done_n++;
          end
        end
        1, 2: begin
          seg = $urandom_range(1, 12);
          for (k = 0; k < seg && done_n < len; k++) begin
            p = pick_pixel();
            if (p == prev_pix) p = ~p;
            send_pixel(p, done_n == len - 1);
            done_n++;
          end
        end
        default: begin
          send_pixel(pick_pixel(), done_n == len - 1);
          done_n++;
        end
      endcase
    end
  endtask

  // ----------------------------------------------------------------- receiver
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (rx_wait != 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      rx_wait = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: header %h, first pixel %h", header_byte_o, pix_first_o);
        errors++;
      end else begin
        want_beat = pending_beats.pop_front();
        check_field("has_header",  24'(want_beat.has_header), 24'(has_header_o));
        check_field("header_byte", 24'(want_beat.header),     24'(header_byte_o));
        check_field("pix_first",   want_beat.pix[0],          pix_first_o);
        check_field("pix_second",  want_beat.pix[1],          pix_second_o);
        check_field("pix_third",   want_beat.pix[2],          pix_third_o);
        check_field("pix_fourth",  want_beat.pix[3],          pix_fourth_o);
        check_field("pix_count",   24'(want_beat.count),      24'(pix_count_o));
        check_field("packet_end",  24'(want_beat.pkt_end),    24'(packet_end_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_tga_rle_scanline_encoder NOT OK");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_line_end_singles();
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b1);
  endtask

  task automatic test_runs();
    send_pixel(24'h5A5A5A, 1'b0);
    send_pixel(24'h5A5A5A, 1'b0);
    send_pixel(24'h5A5A5A, 1'b0);
    send_pixel(24'hA5A5A5, 1'b1);
    send_pixel(24'h800001, 1'b0);
    send_pixel(24'h800001, 1'b0);
    send_pixel(24'h7FFFFE, 1'b0);
    send_pixel(24'h7FFFFE, 1'b1);
  endtask

  task automatic test_raw();
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'hFEDCBA, 1'b0);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h800000, 1'b0);
    send_pixel(24'h7FFFFF, 1'b1);
    send_pixel(24'hAAAAAA, 1'b0);
    send_pixel(24'h555555, 1'b0);
    send_pixel(24'h0F0F0F, 1'b0);
    send_pixel(24'h0F0F0F, 1'b0);
    send_pixel(24'h0F0F0F, 1'b1);
  endtask

  task automatic test_packet_limits();
    int unsigned i;
    for (i = 0; i < 129; i++) send_pixel(24'hC0FFEE, i == 128);
    // the line-end repeat joins the raw packet, which then closes at 128 pixels
    send_distinct(127, 24'hF00000, 1'b1);
  endtask

  task automatic test_backpressure();
    int unsigned start;
    wait_drained();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = 300;
    start      = pixels_sent;
    while (pixels_sent - start < 30) send_scanline($urandom_range(4, 20));
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned start;
    int unsigned len;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 24);
      send_scanline(len);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_line_end_singles();
    test_runs();
    test_raw();
    test_packet_limits();
    test_backpressure();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_random();
    wait_drained();
    $display("Sent %0d pixels in %0d scanlines; checked %0d output beats.",
             pixels_sent, lines_sent, beats_seen);
    $display("Covered single-pixel lines, runs, raw packets, 128-pixel closes, the line-end "
             , "result cap, a long output hold-off and random scanlines.");
    if (errors == 0) begin
      $display("tb_tga_rle_scanline_encoder OK");
    end else begin
      $display("tb_tga_rle_scanline_encoder NOT OK");
    end
    $finish;
  end

endmodule
